>>> rtl/vtsh_pkg.sv
// vtsh_pkg: shared constants, arctangent table and flag struct for the
// speed/heading converter. No dependencies.
package vtsh_pkg;

  // guard bits appended below the integer part of the rotation datapath
  localparam int GUARD_BITS = 28;

  // binary angle: full circle is 2^32
  localparam logic [31:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [31:0] HALF_TURN    = 32'h8000_0000;

  // number of table entries
  localparam int ATAN_ENTRIES = 32;

  // atan(2^-i) as a binary angle, rounded to nearest
  localparam logic [31:0] ATAN_TAB [0:ATAN_ENTRIES-1] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
    32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
    32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051,
    32'h00000029, 32'h00000014, 32'h0000000A, 32'h00000005,
    32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
  };

  // per-item control flags carried alongside the datapath
  typedef struct packed {
    logic neg_u;          // east component negative
    logic neg_v;          // north component negative
    logic angle_zero;     // north component zero: first-quadrant angle is 0
    logic angle_quarter;  // east zero, north nonzero: angle is a quarter turn
  } vtsh_flags_t;

endpackage

>>> rtl/vtsh_in_if.sv
// vtsh_in_if: valid/ready channel carrying one input vector item.
// No dependencies.
interface vtsh_in_if #(
  parameter int COMP_WIDTH = 16
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COMP_WIDTH-1:0] east_comp;
  logic signed [COMP_WIDTH-1:0] north_comp;

  modport source (output valid, east_comp, north_comp, input ready);
  modport sink   (input valid, east_comp, north_comp, output ready);
endinterface

>>> rtl/vtsh_out_if.sv
// vtsh_out_if: valid/ready channel carrying one speed/heading result item.
// No dependencies.
interface vtsh_out_if ();
  logic        valid;
  logic        ready;
  logic [15:0] magnitude;
  logic [15:0] heading;

  modport source (output valid, magnitude, heading, input ready);
  modport sink   (input valid, magnitude, heading, output ready);
endinterface

>>> rtl/vtsh_front.sv
// vtsh_front: absolute values, squares and rotation seed for each item.
// Depends on vtsh_pkg.
module vtsh_front
  import vtsh_pkg::*;
#(
  parameter int COMP_WIDTH = 16,
  parameter int XW         = 47,
  parameter int SW         = 32
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         up_valid,
  output logic                         up_ready,
  input  logic signed [COMP_WIDTH-1:0] east_comp,
  input  logic signed [COMP_WIDTH-1:0] north_comp,
  output logic                         down_valid,
  input  logic                         down_ready,
  output logic signed [XW-1:0]         x_out,
  output logic signed [XW-1:0]         y_out,
  output logic signed [31:0]           z_out,
  output logic [SW-1:0]                n_out,
  output logic [SW-1:0]                r_out,
  output vtsh_flags_t                  flags_out
);

  logic                  s1_valid, s2_valid, s3_valid;
  logic                  s1_ready, s2_ready, s3_ready;
  logic [COMP_WIDTH-1:0] s1_ax, s1_ay, s2_ax, s2_ay;
  vtsh_flags_t           s1_flags, s2_flags, s3_flags;
  logic [SW-1:0]         s2_sqx, s2_sqy, s3_n;
  logic [COMP_WIDTH-1:0] s3_ax, s3_ay;
  logic [COMP_WIDTH-1:0] abs_u, abs_v;
  vtsh_flags_t           in_flags;

  // stage handshake: a stage loads when empty or when its item moves on
  assign s3_ready = !s3_valid || down_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign up_ready = s1_ready;

  // magnitudes; the most negative value maps to 2^(w-1), still in w bits
  always_comb begin
    abs_u = east_comp[COMP_WIDTH-1]  ? (~east_comp + 1'b1)  : east_comp;
    abs_v = north_comp[COMP_WIDTH-1] ? (~north_comp + 1'b1) : north_comp;
    in_flags.neg_u         = east_comp[COMP_WIDTH-1];
    in_flags.neg_v         = north_comp[COMP_WIDTH-1];
    in_flags.angle_zero    = (north_comp == '0);
    in_flags.angle_quarter = (north_comp != '0) && (east_comp == '0);
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
    end else begin
      if (s1_ready) s1_valid <= up_valid;
      if (s2_ready) s2_valid <= s1_valid;
      if (s3_ready) s3_valid <= s2_valid;
    end
  end

  // payload: abs, squares, sum of squares
  always_ff @(posedge clk) begin
    if (s1_ready && up_valid) begin
      s1_ax    <= abs_u;
      s1_ay    <= abs_v;
      s1_flags <= in_flags;
    end
    if (s2_ready && s1_valid) begin
      s2_ax    <= s1_ax;
      s2_ay    <= s1_ay;
      s2_flags <= s1_flags;
      s2_sqx   <= SW'(s1_ax) * SW'(s1_ax);
      s2_sqy   <= SW'(s1_ay) * SW'(s1_ay);
    end
    if (s3_ready && s2_valid) begin
      s3_ax    <= s2_ax;
      s3_ay    <= s2_ay;
      s3_flags <= s2_flags;
      s3_n     <= s2_sqx + s2_sqy;
    end
  end

  // rotation seed: magnitudes scaled by the guard bits
  assign x_out      = XW'(s3_ax) <<< GUARD_BITS;
  assign y_out      = XW'(s3_ay) <<< GUARD_BITS;
  assign z_out      = '0;
  assign n_out      = s3_n;
  assign r_out      = '0;
  assign flags_out  = s3_flags;
  assign down_valid = s3_valid;

endmodule

>>> rtl/vtsh_cell.sv
// vtsh_cell: one cell of the chain; a rotation step below ROTATION_STEPS and a
// root digit below COMP_WIDTH, else pass-through. Depends on vtsh_pkg.
module vtsh_cell
  import vtsh_pkg::*;
#(
  parameter int STAGE          = 0,
  parameter int COMP_WIDTH     = 16,
  parameter int ROTATION_STEPS = 16,
  parameter int XW             = 47,
  parameter int SW             = 32
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 up_valid,
  output logic                 up_ready,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [31:0]   z_in,
  input  logic [SW-1:0]        n_in,
  input  logic [SW-1:0]        r_in,
  input  vtsh_flags_t          flags_in,
  output logic                 down_valid,
  input  logic                 down_ready,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [31:0]   z_out,
  output logic [SW-1:0]        n_out,
  output logic [SW-1:0]        r_out,
  output vtsh_flags_t          flags_out
);

  logic                 valid;
  logic signed [XW-1:0] x_next, y_next;
  logic signed [31:0]   z_next;
  logic [SW-1:0]        n_next, r_next;

  assign up_ready   = !valid || down_ready;
  assign down_valid = valid;

  // rotation step toward the x axis
  if (STAGE < ROTATION_STEPS) begin : g_rot
    always_comb begin
      if (!y_in[XW-1]) begin
        x_next = x_in + (y_in >>> STAGE);
        y_next = y_in - (x_in >>> STAGE);
        z_next = z_in + $signed(ATAN_TAB[STAGE]);
      end else begin
        x_next = x_in - (y_in >>> STAGE);
        y_next = y_in + (x_in >>> STAGE);
        z_next = z_in - $signed(ATAN_TAB[STAGE]);
      end
    end
  end else begin : g_rot_pass
    assign x_next = x_in;
    assign y_next = y_in;
    assign z_next = z_in;
  end

  // one digit of the integer square root
  if (STAGE < COMP_WIDTH) begin : g_root
    localparam logic [SW-1:0] ROOT_BIT = SW'(1) << (2 * (COMP_WIDTH - 1 - STAGE));
    logic [SW-1:0] trial;
    // r has no bits at or below this digit, so or equals add here
    assign trial = r_in | ROOT_BIT;
    always_comb begin
      if (n_in >= trial) begin
        n_next = n_in - trial;
        r_next = (r_in >> 1) + ROOT_BIT;
      end else begin
        n_next = n_in;
        r_next = r_in >> 1;
      end
    end
  end else begin : g_root_pass
    assign n_next = n_in;
    assign r_next = r_in;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      x_out     <= x_next;
      y_out     <= y_next;
      z_out     <= z_next;
      n_out     <= n_next;
      r_out     <= r_next;
      flags_out <= flags_in;
    end
  end

endmodule

>>> rtl/vtsh_back.sv
// vtsh_back: quadrant fold, heading scale and rounding, root rounding and
// the output register. Depends on vtsh_pkg.
module vtsh_back
  import vtsh_pkg::*;
#(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int SW              = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic signed [31:0] z_in,
  input  logic [SW-1:0]      n_in,
  input  logic [SW-1:0]      r_in,
  input  vtsh_flags_t        flags_in,
  output logic               down_valid,
  input  logic               down_ready,
  output logic [15:0]        magnitude,
  output logic [15:0]        heading
);

  localparam int            FW   = 9 + ANGLE_FRAC_BITS;
  localparam logic [FW-1:0] FULL = FW'(360) << ANGLE_FRAC_BITS;
  localparam int            PW   = 32 + FW;

  logic              b1_valid, b2_valid, b3_valid;
  logic              b1_ready, b2_ready, b3_ready;
  logic [31:0]       t_angle, h_next, b1_h;
  logic [SW-1:0]     root_round;
  logic [15:0]       b1_mag, b2_mag;
  logic [PW-1:0]     b2_prod;
  logic [PW:0]       rounded;
  logic [FW:0]       units;

  assign b3_ready   = !b3_valid || down_ready;
  assign b2_ready   = !b2_valid || b3_ready;
  assign b1_ready   = !b1_valid || b2_ready;
  assign up_ready   = b1_ready;
  assign down_valid = b3_valid;

  // first-quadrant angle with clamp and axis cases, then heading angle
  always_comb begin
    if (flags_in.angle_zero) begin
      t_angle = '0;
    end else if (flags_in.angle_quarter) begin
      t_angle = QUARTER_TURN;
    end else if (z_in[31]) begin
      t_angle = '0;
    end else if (z_in > $signed(QUARTER_TURN)) begin
      t_angle = QUARTER_TURN;
    end else begin
      t_angle = z_in;
    end
    case ({flags_in.neg_u, flags_in.neg_v})
      2'b00:   h_next = QUARTER_TURN - t_angle;
      2'b10:   h_next = t_angle - QUARTER_TURN;
      2'b11:   h_next = (32'd0 - QUARTER_TURN) - t_angle;
      2'b01:   h_next = QUARTER_TURN + t_angle;
      default: h_next = '0;
    endcase
    // round the root to nearest
    root_round = (n_in > r_in) ? (r_in + 1'b1) : r_in;
  end

  // heading rounding and wrap of a full circle
  assign rounded = {1'b0, b2_prod} + (PW + 1)'(HALF_TURN);
  assign units   = rounded[PW:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      b2_valid <= 1'b0;
      b3_valid <= 1'b0;
    end else begin
      if (b1_ready) b1_valid <= up_valid;
      if (b2_ready) b2_valid <= b1_valid;
      if (b3_ready) b3_valid <= b2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (b1_ready && up_valid) begin
      b1_h   <= h_next;
      b1_mag <= root_round[15:0];
    end
    if (b2_ready && b1_valid) begin
      b2_prod <= PW'(b1_h) * PW'(FULL);
      b2_mag  <= b1_mag;
    end
    if (b3_ready && b2_valid) begin
      magnitude <= b2_mag;
      heading   <= (units >= (FW + 1)'(FULL)) ? 16'd0 : 16'(units);
    end
  end

endmodule

>>> rtl/vector_to_speed_heading.sv
// Pipeline: vtsh_front, then ROTATION_STEPS or COMP_WIDTH cells, whichever is
// more, then vtsh_back. Throughput: one item per cycle while the output is not
// stalled; every stage of the chain holds its own item and moves it on when
// the next stage is free. Reset clears all stage valid bits; no item is held.
// Depends on vtsh_pkg, vtsh_in_if, vtsh_out_if, vtsh_front, vtsh_cell, vtsh_back.
module vector_to_speed_heading
  import vtsh_pkg::*;
#(
  parameter int COMP_WIDTH      = 16,
  parameter int ROTATION_STEPS  = 16,
  parameter int ANGLE_FRAC_BITS = 7
) (
  input  logic            clk,
  input  logic            rst,
  vtsh_in_if.sink         vec,
  vtsh_out_if.source      result
);

  localparam int XW = COMP_WIDTH + GUARD_BITS + 3;
  localparam int SW = 2 * COMP_WIDTH;
  localparam int N  = (ROTATION_STEPS > COMP_WIDTH) ? ROTATION_STEPS : COMP_WIDTH;

  logic                 c_valid [0:N];
  logic                 c_ready [0:N];
  logic signed [XW-1:0] c_x     [0:N];
  logic signed [XW-1:0] c_y     [0:N];
  logic signed [31:0]   c_z     [0:N];
  logic [SW-1:0]        c_n     [0:N];
  logic [SW-1:0]        c_r     [0:N];
  vtsh_flags_t          c_flags [0:N];

  // abs, squares and seed
  vtsh_front #(
    .COMP_WIDTH (COMP_WIDTH),
    .XW         (XW),
    .SW         (SW)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (vec.valid),
    .up_ready   (vec.ready),
    .east_comp  (vec.east_comp),
    .north_comp (vec.north_comp),
    .down_valid (c_valid[0]),
    .down_ready (c_ready[0]),
    .x_out      (c_x[0]),
    .y_out      (c_y[0]),
    .z_out      (c_z[0]),
    .n_out      (c_n[0]),
    .r_out      (c_r[0]),
    .flags_out  (c_flags[0])
  );

  // chain of rotation and root cells
  for (genvar k = 0; k < N; k++) begin : g_cell
    vtsh_cell #(
      .STAGE          (k),
      .COMP_WIDTH     (COMP_WIDTH),
      .ROTATION_STEPS (ROTATION_STEPS),
      .XW             (XW),
      .SW             (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .up_valid   (c_valid[k]),
      .up_ready   (c_ready[k]),
      .x_in       (c_x[k]),
      .y_in       (c_y[k]),
      .z_in       (c_z[k]),
      .n_in       (c_n[k]),
      .r_in       (c_r[k]),
      .flags_in   (c_flags[k]),
      .down_valid (c_valid[k+1]),
      .down_ready (c_ready[k+1]),
      .x_out      (c_x[k+1]),
      .y_out      (c_y[k+1]),
      .z_out      (c_z[k+1]),
      .n_out      (c_n[k+1]),
      .r_out      (c_r[k+1]),
      .flags_out  (c_flags[k+1])
    );
  end

  // fold, scale, round and output register
  vtsh_back #(
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
    .SW              (SW)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (c_valid[N]),
    .up_ready   (c_ready[N]),
    .z_in       (c_z[N]),
    .n_in       (c_n[N]),
    .r_in       (c_r[N]),
    .flags_in   (c_flags[N]),
    .down_valid (result.valid),
    .down_ready (result.ready),
    .magnitude  (result.magnitude),
    .heading    (result.heading)
  );

endmodule

>>> rtl/vtsh_checker.sv
// vtsh_checker: port-level checks on the speed/heading converter, bound
// to the top level. Depends on vector_to_speed_heading.
module vtsh_checker #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [15:0] magnitude,
  input logic [15:0] heading
);

  localparam int FW = 9 + ANGLE_FRAC_BITS;
  localparam logic [FW-1:0] FULL = FW'(360) << ANGLE_FRAC_BITS;

  // no result right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // an empty output register means the whole chain can take an item
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with output register empty");

  // heading stays below a full circle
  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((FW > 16) || ({{FW{1'b0}}, heading} < {16'd0, FULL})))
    else $error("heading out of range");

  // a stalled result stays
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(magnitude) && $stable(heading))
    else $error("result payload changed while stalled");

endmodule

bind vector_to_speed_heading vtsh_checker #(
  .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
) u_vtsh_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (vec.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .magnitude (result.magnitude),
  .heading   (result.heading)
);
